FILE: hdl/tspg_pkg.sv
// ----------------------------------------------------------------------------
// tspg_pkg
// shared types and constants of the trapezoid step pulse generator
// ----------------------------------------------------------------------------
package tspg_pkg;

  localparam int POSITION_BITS_DEF   = 48;
  localparam int STEP_COUNT_BITS_DEF = 31;
  localparam int DELAY_BITS_DEF      = 16;

  // width of the configuration registers
  localparam int CFG_BITS = 16;

  localparam logic [15:0] MIN_DELAY_RST   = 16'd10;
  localparam logic [15:0] MAX_START_RST   = 16'd2000;
  localparam logic [15:0] RAMP_FRAC_RST   = 16'd13107;
  localparam int          RAMP_MIN        = 5;

  localparam int          ADDR_BITS       = 4;
  localparam logic [1:0]  REG_MIN_DELAY   = 2'd0;
  localparam logic [1:0]  REG_MAX_START   = 2'd1;
  localparam logic [1:0]  REG_RAMP_FRAC   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    C_READY = 3'd0,
    C_PREP  = 3'd1,
    C_MUL   = 3'd2,
    C_DIV   = 3'd3,
    C_FIN   = 3'd4
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic mul;
    logic div;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic need_delay;
  } status_t;

endpackage

FILE: hdl/tspg_datapath.sv
// ----------------------------------------------------------------------------
// tspg_datapath
// move state, step timing and the serial multiply-divide for the step delay
// ----------------------------------------------------------------------------
module tspg_datapath #(
  parameter int POSITION_BITS   = tspg_pkg::POSITION_BITS_DEF,
  parameter int STEP_COUNT_BITS = tspg_pkg::STEP_COUNT_BITS_DEF,
  parameter int DELAY_BITS      = tspg_pkg::DELAY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tspg_pkg::cmd_t             cmd,
  output tspg_pkg::status_t          status,
  input  logic                       tick,
  input  logic                       start_req,
  input  logic                       stop_request,
  input  logic [STEP_COUNT_BITS-1:0] move_steps,
  input  logic                       move_cw,
  input  logic [DELAY_BITS-1:0]      run_delay_us,
  input  logic [15:0]                min_delay_us,
  input  logic [15:0]                start_limit_us,
  input  logic [15:0]                ramp_fraction_q16,
  output logic                       o_pulse,
  output logic                       o_dir_cw,
  output logic [POSITION_BITS-1:0]   o_position,
  output logic                       o_busy_res,
  output logic                       o_finished,
  output logic                       o_aborted,
  output logic [DELAY_BITS-1:0]      o_half_period
);

  localparam int S  = STEP_COUNT_BITS;
  localparam int DW = (DELAY_BITS > tspg_pkg::CFG_BITS) ? DELAY_BITS : tspg_pkg::CFG_BITS;
  localparam int PW = DW + S;

  tspg_pkg::phase_t phase, phase_next;
  logic [S-1:0]             step_index, step_index_next;
  logic [DELAY_BITS-1:0]    tick_count, tick_count_next;
  logic [DELAY_BITS-1:0]    cur_delay, cur_delay_next;
  logic [S-1:0]             total_latched, total_latched_next;
  logic [DW-1:0]            cruise_latched, cruise_latched_next;
  logic [DW-1:0]            start_latched, start_latched_next;
  logic [S-1:0]             ramp_latched, ramp_latched_next;
  logic                     dir_latched, dir_latched_next;
  logic [POSITION_BITS-1:0] step_position, step_position_next;
  logic                     pulse_level, pulse_level_next;

  // work registers of the delay computation
  logic [S-1:0]  k_reg;
  logic [DW-1:0] mag;
  logic          ramping;
  logic          descend;
  logic [PW-1:0] prod;
  logic [S-1:0]  rem;
  logic [DW-1:0] quo;

  logic          done, ab, go_step, need_delay;
  logic [DW-1:0] min_w, rdel_w, run_v, st_v;
  logic [DW+1:0] run_x4, max_w;
  logic [S+15:0] ramp_prod;
  logic [S-1:0]  ramp_v;
  logic [DELAY_BITS-1:0] tc_inc;
  logic [S-1:0]  si_inc;

  logic          in_up, in_down;
  logic [S:0]    trial;
  logic          ge;
  logic [DW-1:0] d_raw, d_clamp;
  logic [DELAY_BITS-1:0] d_fin;

  assign min_w  = DW'(min_delay_us);
  assign rdel_w = DW'(run_delay_us);
  assign run_v  = (rdel_w < min_w) ? min_w : rdel_w;
  assign run_x4 = {run_v, 2'b00};
  assign max_w  = (DW + 2)'(start_limit_us);
  assign st_v   = (run_x4 > max_w) ? max_w[DW-1:0] : run_x4[DW-1:0];
  assign ramp_prod = (S + 16)'(move_steps) * (S + 16)'(ramp_fraction_q16);
  assign ramp_v = (ramp_prod[S+15:16] < S'(tspg_pkg::RAMP_MIN)) ?
                  S'(tspg_pkg::RAMP_MIN) : ramp_prod[S+15:16];
  assign tc_inc = tick_count + 1'b1;
  assign si_inc = step_index + 1'b1;

  always_comb begin
    phase_next          = phase;
    step_index_next     = step_index;
    tick_count_next     = tick_count;
    cur_delay_next      = cur_delay;
    total_latched_next  = total_latched;
    cruise_latched_next = cruise_latched;
    start_latched_next  = start_latched;
    ramp_latched_next   = ramp_latched;
    dir_latched_next    = dir_latched;
    step_position_next  = step_position;
    pulse_level_next    = pulse_level;
    done       = 1'b0;
    ab         = 1'b0;
    go_step    = 1'b0;
    need_delay = 1'b0;
    if (cmd.accept) begin
      if (phase != tspg_pkg::PH_HIGH && phase != tspg_pkg::PH_LOW) begin
        phase_next = tspg_pkg::PH_IDLE;
        if (start_req) begin
          if (move_steps == '0 || run_delay_us == '0) begin
            done = 1'b1;
          end else begin
            total_latched_next  = move_steps;
            cruise_latched_next = run_v;
            start_latched_next  = st_v;
            ramp_latched_next   = ramp_v;
            dir_latched_next    = move_cw;
            step_index_next     = '0;
            go_step             = 1'b1;
          end
        end
      end else if (tick) begin
        tick_count_next = tc_inc;
        if (tc_inc >= cur_delay || tc_inc == '0) begin
          tick_count_next = '0;
          if (phase == tspg_pkg::PH_HIGH) begin
            pulse_level_next = 1'b0;
            phase_next       = tspg_pkg::PH_LOW;
          end else begin
            step_index_next = si_inc;
            if (si_inc >= total_latched || si_inc == '0) begin
              phase_next = tspg_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              go_step = 1'b1;
            end
          end
        end
      end
      if (go_step) begin
        if (stop_request) begin
          phase_next       = tspg_pkg::PH_IDLE;
          pulse_level_next = 1'b0;
          done             = 1'b1;
          ab               = 1'b1;
        end else begin
          need_delay         = 1'b1;
          step_position_next = dir_latched_next ? step_position + 1'b1 : step_position - 1'b1;
          pulse_level_next   = 1'b1;
          tick_count_next    = '0;
          phase_next         = tspg_pkg::PH_HIGH;
        end
      end
    end
    if (cmd.fin) begin
      cur_delay_next = d_fin;
    end
  end

  assign status.need_delay = need_delay;

  // ramp position of the current step
  assign in_up   = step_index < ramp_latched;
  assign in_down = step_index >= (total_latched - ramp_latched);

  // restoring division, one quotient bit a cycle
  assign trial = {rem, prod[PW-1]};
  assign ge    = trial >= {1'b0, ramp_latched};

  always_comb begin
    if (!ramping) begin
      d_raw = cruise_latched;
    end else if (descend) begin
      d_raw = start_latched - quo;
    end else begin
      d_raw = start_latched + quo;
    end
    d_clamp = (d_raw < min_w) ? min_w : d_raw;
    if (d_clamp == '0) begin
      d_clamp = DW'(1);
    end
    d_fin = d_clamp[DELAY_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= tspg_pkg::PH_IDLE;
      step_index     <= '0;
      tick_count     <= '0;
      cur_delay      <= '0;
      total_latched  <= '0;
      cruise_latched <= '0;
      start_latched  <= '0;
      ramp_latched   <= S'(tspg_pkg::RAMP_MIN);
      dir_latched    <= 1'b1;
      step_position  <= '0;
      pulse_level    <= 1'b0;
    end else begin
      phase          <= phase_next;
      step_index     <= step_index_next;
      tick_count     <= tick_count_next;
      cur_delay      <= cur_delay_next;
      total_latched  <= total_latched_next;
      cruise_latched <= cruise_latched_next;
      start_latched  <= start_latched_next;
      ramp_latched   <= ramp_latched_next;
      dir_latched    <= dir_latched_next;
      step_position  <= step_position_next;
      pulse_level    <= pulse_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ramping <= in_up || in_down;
      k_reg   <= in_up ? step_index : (total_latched - 1'b1 - step_index);
      descend <= start_latched >= cruise_latched;
      mag     <= (start_latched >= cruise_latched) ? start_latched - cruise_latched
                                                   : cruise_latched - start_latched;
    end
    if (cmd.mul) begin
      prod <= PW'(mag) * PW'(k_reg);
      rem  <= '0;
      quo  <= '0;
    end
    if (cmd.div) begin
      rem  <= ge ? S'(trial - {1'b0, ramp_latched}) : trial[S-1:0];
      prod <= {prod[PW-2:0], 1'b0};
      quo  <= {quo[DW-2:0], ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.accept && !need_delay) begin
      o_pulse       <= pulse_level_next;
      o_dir_cw      <= dir_latched_next;
      o_position    <= step_position_next;
      o_busy_res    <= (phase_next == tspg_pkg::PH_HIGH) || (phase_next == tspg_pkg::PH_LOW);
      o_finished    <= done;
      o_aborted     <= ab;
      o_half_period <= cur_delay_next;
    end else if (cmd.fin) begin
      o_pulse       <= pulse_level;
      o_dir_cw      <= dir_latched;
      o_position    <= step_position;
      o_busy_res    <= 1'b1;
      o_finished    <= 1'b0;
      o_aborted     <= 1'b0;
      o_half_period <= d_fin;
    end
  end

endmodule

FILE: hdl/tspg_ctrl.sv
// ----------------------------------------------------------------------------
// tspg_ctrl
// sequencer for item acceptance, the delay computation and the result slot
// ----------------------------------------------------------------------------
module tspg_ctrl #(
  parameter int STEP_COUNT_BITS = tspg_pkg::STEP_COUNT_BITS_DEF,
  parameter int DELAY_BITS      = tspg_pkg::DELAY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  tspg_pkg::status_t status,
  output tspg_pkg::cmd_t    cmd
);

  localparam int DW = (DELAY_BITS > tspg_pkg::CFG_BITS) ? DELAY_BITS : tspg_pkg::CFG_BITS;
  localparam int PW = DW + STEP_COUNT_BITS;
  localparam int CW = $clog2(PW);

  tspg_pkg::ctrl_state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          m_tvalid_next;
  logic          div_last;

  assign div_last = cnt == CW'(PW - 1);
  assign s_tready = (state == tspg_pkg::C_READY) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.accept = s_tvalid && s_tready;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      tspg_pkg::C_READY: begin
        if (cmd.accept) begin
          if (status.need_delay) begin
            state_next = tspg_pkg::C_PREP;
          end else begin
            m_tvalid_next = 1'b1;
          end
        end
      end
      tspg_pkg::C_PREP: begin
        cmd.prep   = 1'b1;
        state_next = tspg_pkg::C_MUL;
      end
      tspg_pkg::C_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = '0;
        state_next = tspg_pkg::C_DIV;
      end
      tspg_pkg::C_DIV: begin
        cmd.div  = 1'b1;
        cnt_next = cnt + 1'b1;
        if (div_last) begin
          state_next = tspg_pkg::C_FIN;
        end
      end
      tspg_pkg::C_FIN: begin
        cmd.fin       = 1'b1;
        m_tvalid_next = 1'b1;
        state_next    = tspg_pkg::C_READY;
      end
      default: begin
        state_next = tspg_pkg::C_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tspg_pkg::C_READY;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_step_goes_to_prep: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && status.need_delay) |=> (state == tspg_pkg::C_PREP))
    else $error("step start did not launch the delay computation");

  a_div_ends_in_fin: assert property (@(posedge clk) disable iff (rst)
    (state == tspg_pkg::C_DIV && div_last) |=> (state == tspg_pkg::C_FIN))
    else $error("division did not finish after its last bit");

  a_fin_shows_result: assert property (@(posedge clk) disable iff (rst)
    (state == tspg_pkg::C_FIN) |=> m_tvalid)
    else $error("finished step start left no result");

  a_slot_free_while_working: assert property (@(posedge clk) disable iff (rst)
    (state == tspg_pkg::C_PREP || state == tspg_pkg::C_MUL || state == tspg_pkg::C_DIV)
      |-> !m_tvalid)
    else $error("result slot occupied during delay computation");

endmodule

FILE: hdl/trapezoid_step_pulse_generator_unit.sv
// ----------------------------------------------------------------------------
// trapezoid_step_pulse_generator_unit
// trapezoidal ramp step pulse generator with stream ports and apb registers
// ----------------------------------------------------------------------------
// Each input item is one microsecond tick plus start/stop commands and the move
// settings; each item yields exactly one result item with the pulse level,
// direction, signed position, busy, done/aborted flags and the half-period of
// the current step. An item that does not begin a step is answered straight
// from the result register, and such items can follow each other every cycle
// while the result slot is free or being taken. An item that begins a step
// (the start item, or the tick that closes the low phase of a step) runs the
// ramp delay through a shift-subtract divider over |start-cruise|*k, one
// quotient bit a cycle, through the prep, mul, div and fin states; the block
// takes no new item before that ends. Registers are to be written over apb
// only while the block is idle; the block itself does not enforce it.
module trapezoid_step_pulse_generator_unit #(
  parameter int POSITION_BITS   = tspg_pkg::POSITION_BITS_DEF,
  parameter int STEP_COUNT_BITS = tspg_pkg::STEP_COUNT_BITS_DEF,
  parameter int DELAY_BITS      = tspg_pkg::DELAY_BITS_DEF,
  localparam int IN_BITS  = 3 + STEP_COUNT_BITS + 1 + DELAY_BITS,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 2 + POSITION_BITS + 3 + DELAY_BITS,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // tick, start_req, stop_request, move_steps, move_cw, run_delay_us
  input  logic [IN_W-1:0]               s_tdata,
  // result item
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pulse, dir_cw, position, busy_res, done, aborted, half_period
  output logic [OUT_W-1:0]              m_tdata,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tspg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int S = STEP_COUNT_BITS;

  tspg_pkg::cmd_t    cmd;
  tspg_pkg::status_t status;

  logic [15:0] min_delay_us;
  logic [15:0] start_limit_us;
  logic [15:0] ramp_fraction_q16;
  logic [1:0]  reg_idx;
  logic        wr_en;

  logic                     o_pulse, o_dir_cw, o_busy_res, o_finished, o_aborted;
  logic [POSITION_BITS-1:0] o_position;
  logic [DELAY_BITS-1:0]    o_half_period;

  // apb registers, word addressed
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay_us      <= tspg_pkg::MIN_DELAY_RST;
      start_limit_us    <= tspg_pkg::MAX_START_RST;
      ramp_fraction_q16 <= tspg_pkg::RAMP_FRAC_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tspg_pkg::REG_MIN_DELAY: min_delay_us      <= pwdata[15:0];
        tspg_pkg::REG_MAX_START: start_limit_us    <= pwdata[15:0];
        tspg_pkg::REG_RAMP_FRAC: ramp_fraction_q16 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tspg_pkg::REG_MIN_DELAY: prdata = {16'b0, min_delay_us};
      tspg_pkg::REG_MAX_START: prdata = {16'b0, start_limit_us};
      tspg_pkg::REG_RAMP_FRAC: prdata = {16'b0, ramp_fraction_q16};
      default:                 prdata = '0;
    endcase
  end

  tspg_ctrl #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS),
    .DELAY_BITS     (DELAY_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // unpack the input item, tick in bit 0
  tspg_datapath #(
    .POSITION_BITS  (POSITION_BITS),
    .STEP_COUNT_BITS(STEP_COUNT_BITS),
    .DELAY_BITS     (DELAY_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .tick              (s_tdata[0]),
    .start_req         (s_tdata[1]),
    .stop_request      (s_tdata[2]),
    .move_steps        (s_tdata[3 +: S]),
    .move_cw           (s_tdata[3 + S]),
    .run_delay_us      (s_tdata[4 + S +: DELAY_BITS]),
    .min_delay_us      (min_delay_us),
    .start_limit_us    (start_limit_us),
    .ramp_fraction_q16 (ramp_fraction_q16),
    .o_pulse           (o_pulse),
    .o_dir_cw          (o_dir_cw),
    .o_position        (o_position),
    .o_busy_res        (o_busy_res),
    .o_finished        (o_finished),
    .o_aborted         (o_aborted),
    .o_half_period     (o_half_period)
  );

  // pack the result item, pulse in bit 0, zero padded to whole bytes
  assign m_tdata = OUT_W'({o_half_period, o_aborted, o_finished, o_busy_res,
                           o_position, o_dir_cw, o_pulse});

endmodule
